// ===== rtl/core/lge_pkg.sv =====
// Shared types, constants and the B3/S23 row function for the life grid engine.
package lge_pkg;

   localparam int GRID_SIZE = 64;
   localparam int ROW_W     = $clog2(GRID_SIZE);
   localparam int STEP_W    = $clog2(GRID_SIZE + 2);

   localparam int OP_W      = 2;
   localparam int COORD_W   = 6;
   localparam int GEN_W     = 32;
   localparam int REQ_W     = 16;
   localparam int RSP_W     = 40;

   localparam logic [3:0] BIRTH_COUNT = 4'd3;
   localparam logic [3:0] KEEP_COUNT  = 4'd2;

   typedef enum logic [OP_W-1:0] {
      OP_STEP   = 2'd0,
      OP_TOGGLE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_STEP  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // B3/S23 over one row, cells beyond either end count as dead
   function automatic logic [GRID_SIZE-1:0] life_row(input logic [GRID_SIZE-1:0] up,
                                                     input logic [GRID_SIZE-1:0] mid,
                                                     input logic [GRID_SIZE-1:0] dn);
      logic [GRID_SIZE+1:0] pu;
      logic [GRID_SIZE+1:0] pm;
      logic [GRID_SIZE+1:0] pd;
      logic [3:0]           n;
      logic [GRID_SIZE-1:0] res;
      pu = {1'b0, up, 1'b0};
      pm = {1'b0, mid, 1'b0};
      pd = {1'b0, dn, 1'b0};
      for (int c = 0; c < GRID_SIZE; c++) begin
         n = 4'(pu[c]) + 4'(pu[c+1]) + 4'(pu[c+2])
           + 4'(pm[c]) + 4'(pm[c+2])
           + 4'(pd[c]) + 4'(pd[c+1]) + 4'(pd[c+2]);
         res[c] = (n == BIRTH_COUNT) || ((n == KEEP_COUNT) && mid[c]);
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/life_grid_engine.sv =====
// Life grid engine: row-serial B3/S23 generation step over a row memory, plus cell toggle, cell read and grid clear.
//
//   channel | dir | word fields (lsb up)                       | accept
//   req     | in  | operation[1:0] row[7:2] col[13:8] pad      | req_tvalid & req_tready
//   rsp     | out | cell_alive[0] generation[32:1] pad         | rsp_tvalid & rsp_tready
//
// A step streams rows through a three-row window, one row per cycle, writing each
// new row back once the row below it has been read, then enters DONE for the result.
// Toggle and read wait in FETCH for the registered memory read; clear goes to DONE.
// Reset clears the row valid bits at once; an invalid row reads as all dead.
// A pending result holds in the output register while the next word is accepted;
// the next result waits in DONE while that register is still full.
module life_grid_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [lge_pkg::REQ_W-1:0] req_tdata,  // operation, row, col
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [lge_pkg::RSP_W-1:0] rsp_tdata   // cell_alive, generation
);

   localparam int N = lge_pkg::GRID_SIZE;

   lge_pkg::state_type state_ff, state_in;

   logic [lge_pkg::OP_W-1:0]    op_ff, op_in;
   logic [lge_pkg::COORD_W-1:0] row_ff, row_in;
   logic [lge_pkg::COORD_W-1:0] col_ff, col_in;
   logic [lge_pkg::STEP_W-1:0]  s_ff, s_in;
   logic [lge_pkg::GEN_W-1:0]   gen_ff, gen_in;
   logic [N-1:0]                above_ff, above_in;
   logic [N-1:0]                cur_ff, cur_in;
   logic                        cell_ff, cell_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_cell_ff, rsp_cell_in;
   logic [lge_pkg::GEN_W-1:0]   rsp_gen_ff, rsp_gen_in;

   logic [N-1:0]                grid_mem [N];
   logic [N-1:0]                row_valid_ff;
   logic [N-1:0]                rd_data_ff;
   logic                        rd_hit_ff;

   logic                        rd_en;
   logic [lge_pkg::ROW_W-1:0]   rd_addr;
   logic                        wr_en;
   logic [lge_pkg::ROW_W-1:0]   wr_addr;
   logic [N-1:0]                wr_data;
   logic                        clr_all;

   logic                        req_fire;
   lge_pkg::op_type             req_op;
   logic [lge_pkg::COORD_W-1:0] req_row;
   logic [lge_pkg::COORD_W-1:0] req_col;
   logic                        req_inside;
   logic                        in_grid;
   logic [lge_pkg::ROW_W-1:0]   row_idx;
   logic [lge_pkg::ROW_W-1:0]   col_idx;
   logic [N-1:0]                below;
   logic [N-1:0]                toggled;

   assign req_op     = lge_pkg::op_type'(req_tdata[1:0]);
   assign req_row    = req_tdata[7:2];
   assign req_col    = req_tdata[13:8];
   assign req_inside = (int'(req_row) < N) && (int'(req_col) < N);
   assign in_grid    = (int'(row_ff) < N) && (int'(col_ff) < N);
   assign row_idx    = lge_pkg::ROW_W'(row_ff);
   assign col_idx    = lge_pkg::ROW_W'(col_ff);

   assign req_tready = (state_ff == lge_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign below   = rd_hit_ff ? rd_data_ff : '0;
   assign toggled = below ^ (N'(1) << col_idx);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(lge_pkg::RSP_W - lge_pkg::GEN_W - 1){1'b0}}, rsp_gen_ff, rsp_cell_ff};

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      s_in         = s_ff;
      gen_in       = gen_ff;
      above_in     = above_ff;
      cur_in       = cur_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_gen_in   = rsp_gen_ff;
      rd_en        = 1'b0;
      rd_addr      = lge_pkg::ROW_W'(req_row);
      wr_en        = 1'b0;
      wr_addr      = row_idx;
      wr_data      = toggled;
      clr_all      = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         lge_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in   = req_op;
               row_in  = req_row;
               col_in  = req_col;
               cell_in = 1'b0;
               unique case (req_op)
                  lge_pkg::OP_STEP: begin
                     gen_in   = gen_ff + lge_pkg::GEN_W'(1);
                     s_in     = '0;
                     state_in = lge_pkg::ST_STEP;
                  end
                  lge_pkg::OP_CLEAR: begin
                     clr_all  = 1'b1;
                     gen_in   = '0;
                     state_in = lge_pkg::ST_DONE;
                  end
                  default: begin
                     rd_en    = req_inside;
                     state_in = lge_pkg::ST_FETCH;
                  end
               endcase
            end
         end
         lge_pkg::ST_FETCH: begin
            if (in_grid) begin
               if (op_ff == lge_pkg::OP_TOGGLE) begin
                  wr_en   = 1'b1;
                  cell_in = toggled[col_idx];
               end else begin
                  cell_in = below[col_idx];
               end
            end
            state_in = lge_pkg::ST_DONE;
         end
         lge_pkg::ST_STEP: begin
            // read row s, window holds rows s-3 and s-2, row s-1 arrives as below
            rd_en   = (s_ff < lge_pkg::STEP_W'(N));
            rd_addr = lge_pkg::ROW_W'(s_ff);
            if (s_ff == '0) begin
               above_in = '0;
               cur_in   = '0;
            end else begin
               above_in = cur_ff;
               cur_in   = below;
            end
            if (s_ff >= lge_pkg::STEP_W'(2)) begin
               wr_en   = 1'b1;
               wr_addr = lge_pkg::ROW_W'(s_ff - lge_pkg::STEP_W'(2));
               wr_data = lge_pkg::life_row(above_ff, cur_ff, below);
               if (in_grid && (wr_addr == row_idx)) begin
                  cell_in = wr_data[col_idx];
               end
            end
            s_in = s_ff + lge_pkg::STEP_W'(1);
            if (s_ff == lge_pkg::STEP_W'(N + 1)) begin
               state_in = lge_pkg::ST_DONE;
            end
         end
         lge_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = cell_ff;
               rsp_gen_in   = gen_ff;
               state_in     = lge_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lge_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lge_pkg::ST_IDLE;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         s_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
         s_ff         <= s_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      above_ff    <= above_in;
      cur_ff      <= cur_in;
      cell_ff     <= cell_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_gen_ff  <= rsp_gen_in;
   end

   // row memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_hit_ff    <= 1'b0;
      end else begin
         if (clr_all) begin
            row_valid_ff <= '0;
         end else if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         rd_hit_ff <= rd_en && row_valid_ff[rd_addr];
      end
   end

`ifndef ASSERT_OFF
   a_no_write_on_clear: assert property (@(posedge clock) disable iff (reset)
      !(clr_all && wr_en))
      else $error("row write during grid clear");

   a_step_write_lags: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lge_pkg::ST_STEP) && wr_en |-> (s_ff >= lge_pkg::STEP_W'(2)))
      else $error("step wrote a row before its window was full");

   a_clear_zeroes_gen: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_op == lge_pkg::OP_CLEAR) |=> (gen_ff == '0))
      else $error("clear left the generation counter nonzero");

   a_step_counts: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_op == lge_pkg::OP_STEP)
      |=> (gen_ff == $past(gen_ff) + lge_pkg::GEN_W'(1)))
      else $error("step did not advance the generation counter");
`endif

endmodule
